/* sv/bus_latency_stats_monitor_defines.svh */
// assertion macros for the bus latency statistics monitor
`ifndef BUS_LATENCY_STATS_MONITOR_DEFINES_SVH
`define BUS_LATENCY_STATS_MONITOR_DEFINES_SVH

// property checked on every clock edge outside reset
`define BLSM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies a consequence in the next
`define BLSM_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

/* sv/blsm_pkg.sv */
// shared types and constants of the bus latency statistics monitor
`timescale 1ns / 1ps

package blsm_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned CntW     = 32;
  localparam int unsigned SumW     = 48;
  localparam int unsigned BinIdxW  = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 320;

  localparam logic [TimeW-1:0] TimeMax     = 16'hFFFF;
  localparam logic [TimeW-1:0] DeadlineRst = 16'd19;
  localparam logic [TimeW-1:0] HoldRst     = 16'd2;

  typedef enum logic [OpW-1:0] {
    OP_START  = 2'd0,
    OP_RECORD = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEADLINE = 1'b0,
    CFG_HOLD     = 1'b1
  } cfg_idx_e;

endpackage

/* sv/bus_latency_stats_monitor.sv */
// bus latency statistics monitor: counters, extremes and latency histogram
`timescale 1ns / 1ps
`include "bus_latency_stats_monitor_defines.svh"

// Takes one item per clock, back to back, and returns one result item for each. An item
// accepted from the slave side moves on to the update stage, leaves it into the output
// register and is taken from there on the master side; master-side stalls can hold it
// in either register.
// The histogram of HIST_BINS 32-bit bins lives in a single-port-read, single-port-write
// memory: the bin is read in the cycle the item is accepted and written back when the
// item leaves the update stage, and a same-cycle forward covers two items in a row
// hitting the same bin. A start item clears the whole histogram at once
// through one valid flag per bin, so no clearing sweep is needed and there is no dead
// time after reset or after start. The output register lets a new item enter while a
// finished result waits; the rate only drops when the master side stalls.
module bus_latency_stats_monitor import blsm_pkg::*; #(
  parameter int unsigned HIST_BINS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [TimeW-1:0]    cfg_wdata_i,
  // slave side
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: edge_time, done_time, work_done_time, qfall_time, late, overcapture, bin_index
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: operation
  input  logic [OpW-1:0]      s_axis_tuser,
  // master side
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: cycles_recorded, deadline miss count, hold violation count, overrun_count,
  // latency_worst, latency_best, latency_total, period_least, period_most,
  // slack_least, late_count, bin_count
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned AW = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
  localparam logic [AW-1:0]    TopBin = AW'(HIST_BINS - 1);
  localparam logic [TimeW-1:0] BinsT  = TimeW'(HIST_BINS);

  // item held in the update stage
  typedef struct packed {
    op_e              op;
    logic [TimeW-1:0] edge_t;
    logic [TimeW-1:0] lat;
    logic [TimeW-1:0] slack;
    logic             late;
    logic             ovr;
    logic [AW-1:0]    addr;
    logic             bin_ok;
  } s1_t;

  // configuration registers
  logic [TimeW-1:0] deadline_q, hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= DeadlineRst;
      hold_q     <= HoldRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEADLINE: deadline_q <= cfg_wdata_i;
        CFG_HOLD:     hold_q     <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // input item fields
  logic [TimeW-1:0]   in_edge, in_done, in_work, in_qfall, in_lat, in_slack;
  logic               in_late, in_ovr, in_bin_ok;
  logic [BinIdxW-1:0] in_bin;
  op_e                in_op;
  logic [AW-1:0]      rec_addr, rd_addr;

  assign in_op    = op_e'(s_axis_tuser);
  assign in_edge  = s_axis_tdata[15:0];
  assign in_done  = s_axis_tdata[31:16];
  assign in_work  = s_axis_tdata[47:32];
  assign in_qfall = s_axis_tdata[63:48];
  assign in_late  = s_axis_tdata[64];
  assign in_ovr   = s_axis_tdata[65];
  assign in_bin   = s_axis_tdata[71:66];

  // wrapping differences
  assign in_lat   = in_done - in_edge;
  assign in_slack = in_qfall - in_work;

  // top bin saturates
  assign rec_addr  = (in_lat < BinsT) ? in_lat[AW-1:0] : TopBin;
  assign in_bin_ok = (32'(in_bin) < HIST_BINS);
  assign rd_addr   = (in_op == OP_READ) ? AW'(in_bin) : rec_addr;

  // handshake and stage control
  logic s1_vld_q, s1_adv, s_acc, out_vld_q, rd_en;
  s1_t  s1_q;

  assign s1_adv        = s1_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || s1_adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign rd_en         = s_acc && ((in_op == OP_RECORD) || (in_op == OP_READ));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_q.op     <= in_op;
      s1_q.edge_t <= in_edge;
      s1_q.lat    <= in_lat;
      s1_q.slack  <= in_slack;
      s1_q.late   <= in_late;
      s1_q.ovr    <= in_ovr;
      s1_q.addr   <= rd_addr;
      s1_q.bin_ok <= in_bin_ok;
    end
  end

  // histogram memory, read at accept, written when the record item leaves the update stage
  logic [CntW-1:0]      hist_mem [HIST_BINS];
  logic [CntW-1:0]      rdata_q, fwd_data_q, old_cnt, hist_wdata;
  logic                 fwd_hit_q, hist_we;
  logic [HIST_BINS-1:0] bin_vld_q;

  assign hist_we    = s1_adv && (s1_q.op == OP_RECORD);
  assign old_cnt    = bin_vld_q[s1_q.addr] ? (fwd_hit_q ? fwd_data_q : rdata_q) : '0;
  assign hist_wdata = old_cnt + CntW'(1);

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[s1_q.addr] <= hist_wdata;
    end
    if (rd_en) begin
      rdata_q <= hist_mem[rd_addr];
    end
    if (s_acc) begin
      fwd_data_q <= hist_wdata;
    end
  end

  // forward when the bin is written in the same cycle it is read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (s_acc) begin
      fwd_hit_q <= hist_we && (s1_q.addr == rd_addr);
    end
  end

  // a bin that is not valid reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_vld_q <= '0;
    end else if (s1_adv && (s1_q.op == OP_START)) begin
      bin_vld_q <= '0;
    end else if (hist_we) begin
      bin_vld_q[s1_q.addr] <= 1'b1;
    end
  end

  // scalar statistics
  logic [TimeW-1:0] prev_edge_q, prev_edge_d, period;
  logic [CntW-1:0]  cyc_q, cyc_d, miss_q, miss_d, hold_cnt_q, hold_cnt_d;
  logic [CntW-1:0]  ovr_q, ovr_d, late_q, late_d, bin_cnt;
  logic [TimeW-1:0] worst_q, worst_d, best_q, best_d;
  logic [TimeW-1:0] pmin_q, pmin_d, pmax_q, pmax_d, smin_q, smin_d;
  logic [SumW-1:0]  lat_sum_q, lat_sum_d;

  assign period = s1_q.edge_t - prev_edge_q;

  always_comb begin
    prev_edge_d = prev_edge_q;
    cyc_d       = cyc_q;
    miss_d      = miss_q;
    hold_cnt_d  = hold_cnt_q;
    ovr_d       = ovr_q;
    late_d      = late_q;
    worst_d     = worst_q;
    best_d      = best_q;
    pmin_d      = pmin_q;
    pmax_d      = pmax_q;
    smin_d      = smin_q;
    lat_sum_d   = lat_sum_q;
    bin_cnt     = '0;
    if (s1_adv) begin
      case (s1_q.op)
        OP_START: begin
          prev_edge_d = s1_q.edge_t;
          cyc_d       = '0;
          miss_d      = '0;
          hold_cnt_d  = '0;
          ovr_d       = '0;
          late_d      = '0;
          worst_d     = '0;
          best_d      = TimeMax;
          pmin_d      = TimeMax;
          pmax_d      = '0;
          smin_d      = TimeMax;
          lat_sum_d   = '0;
        end
        OP_RECORD: begin
          prev_edge_d = s1_q.edge_t;
          cyc_d       = cyc_q + CntW'(1);
          if (s1_q.late) begin
            late_d = late_q + CntW'(1);
          end else if (s1_q.slack < smin_q) begin
            smin_d = s1_q.slack;
          end
          if (s1_q.ovr) begin
            ovr_d = ovr_q + CntW'(1);
          end
          if (s1_q.lat > deadline_q) begin
            miss_d = miss_q + CntW'(1);
          end
          if (s1_q.lat < hold_q) begin
            hold_cnt_d = hold_cnt_q + CntW'(1);
          end
          if (s1_q.lat > worst_q) begin
            worst_d = s1_q.lat;
          end
          if (s1_q.lat < best_q) begin
            best_d = s1_q.lat;
          end
          lat_sum_d = lat_sum_q + SumW'(s1_q.lat);
          if (period < pmin_q) begin
            pmin_d = period;
          end
          if (period > pmax_q) begin
            pmax_d = period;
          end
        end
        OP_READ: begin
          if (s1_q.bin_ok) begin
            bin_cnt = old_cnt;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_edge_q <= '0;
      cyc_q       <= '0;
      miss_q      <= '0;
      hold_cnt_q  <= '0;
      ovr_q       <= '0;
      late_q      <= '0;
      worst_q     <= '0;
      best_q      <= TimeMax;
      pmin_q      <= TimeMax;
      pmax_q      <= '0;
      smin_q      <= TimeMax;
      lat_sum_q   <= '0;
    end else begin
      prev_edge_q <= prev_edge_d;
      cyc_q       <= cyc_d;
      miss_q      <= miss_d;
      hold_cnt_q  <= hold_cnt_d;
      ovr_q       <= ovr_d;
      late_q      <= late_d;
      worst_q     <= worst_d;
      best_q      <= best_d;
      pmin_q      <= pmin_d;
      pmax_q      <= pmax_d;
      smin_q      <= smin_d;
      lat_sum_q   <= lat_sum_d;
    end
  end

  // output register
  logic [OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= {bin_cnt, late_d, smin_d, pmax_d, pmin_d, lat_sum_d,
                     best_d, worst_d, ovr_d, hold_cnt_d, miss_d, cyc_d};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // once anything is recorded the best latency cannot exceed the worst
  `BLSM_ASSERT(a_best_le_worst, (cyc_q != '0) |-> (best_q <= worst_q), "best latency above worst")
  // a start leaves every histogram bin empty
  `BLSM_ASSERT_NEXT(a_start_clears, s1_adv && (s1_q.op == OP_START), bin_vld_q == '0, "bins not cleared")
  // a result appears only after an item left the update stage
  `BLSM_ASSERT(a_out_from_s1, $rose(out_vld_q) |-> $past(s1_adv), "result without item")
  // the latency sum grows by exactly the recorded latency
  `BLSM_ASSERT_NEXT(a_sum_step, s1_adv && (s1_q.op == OP_RECORD), lat_sum_q == $past(lat_sum_q + SumW'(s1_q.lat)), "latency sum mismatch")

endmodule
